// File: hdl/bmw_pkg.sv
// Package for the binary morphology window block.
// Sizes, register codes, mode codes and the structs shared by the modules that import it.
// No dependencies.
package bmw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WINDOW = 15;

  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int DIM_W  = 11;
  localparam int K_W    = 4;
  localparam int HIST_W = MAX_WINDOW - 1;
  localparam int WIN_W  = MAX_WINDOW;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    MODE_ERODE    = 2'd0,
    MODE_DILATE   = 2'd1,
    MODE_GRADIENT = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [K_W-1:0]     k;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               px;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } item_t;

endpackage

// File: hdl/bmw_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read data holds between reads; a read and write to one entry return old data.
// No dependencies.
module bmw_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 14,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bmw_regs.sv
// Configuration registers of the morphology block behind an APB-style port.
// Holds raw register values and derives the effective window and image size.
// Depends on bmw_pkg.
module bmw_regs
  import bmw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [1:0]       mode_q;
  logic [K_W-1:0]   window_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd0;
      window_q <= K_W'(3);
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
    end else if (wr_en) begin
      case (idx)
        REG_MODE:   mode_q   <= pwdata[1:0];
        REG_WINDOW: window_q <= pwdata[K_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_WINDOW: prdata = APB_DW'(window_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.mode = mode_e'(mode_q);
    cfg_o.k    = window_q | K_W'(1);
    if (width_q == '0) begin
      cfg_o.width = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      cfg_o.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      cfg_o.height = DIM_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
  end

endmodule

// File: hdl/bmw_scan.sv
// Input stage: takes pixel items, tracks the raster position and issues the
// column history read. Holds the item for the window stage. Depends on bmw_pkg.
module bmw_scan
  import bmw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             pixel_i,
  input  logic             frame_start_i,
  input  logic             s1_adv_i,
  output logic             rd_en_o,
  output logic [COL_W-1:0] rd_addr_o,
  output item_t            s1_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [DIM_W-1:0] c_nxt, r_nxt;
  logic             accept;
  item_t            s1_q;

  assign in_stall_o = s1_q.valid && !s1_adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign r0         = frame_start_i ? '0 : row_q;
  assign c0         = frame_start_i ? '0 : col_q;
  assign rd_en_o    = accept;
  assign rd_addr_o  = c0;

  always_comb begin
    c_nxt = {1'b0, c0} + DIM_W'(1);
    r_nxt = {1'b0, r0} + DIM_W'(1);
    col_d = c_nxt[COL_W-1:0];
    row_d = r0;
    if (c_nxt >= cfg_i.width) begin
      col_d = '0;
      row_d = (r_nxt >= cfg_i.height) ? '0 : r_nxt[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      s1_q  <= '0;
    end else if (accept) begin
      row_q    <= row_d;
      col_q    <= col_d;
      s1_q.valid <= 1'b1;
      s1_q.px  <= pixel_i;
      s1_q.row <= r0;
      s1_q.col <= c0;
    end else if (s1_adv_i) begin
      s1_q.valid <= 1'b0;
    end
  end

  assign s1_o = s1_q;

endmodule

// File: hdl/bmw_window.sv
// Window stage: updates one column history entry, forwards a same-entry write,
// shifts the window column flags and registers the result item.
// Depends on bmw_pkg.
module bmw_window
  import bmw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  item_t             s1_i,
  output logic              s1_adv_o,
  input  logic              rd_en_i,
  input  logic [COL_W-1:0]  rd_addr_i,
  input  logic [HIST_W-1:0] rd_data_i,
  output logic              wr_en_o,
  output logic [COL_W-1:0]  wr_addr_o,
  output logic [HIST_W-1:0] wr_data_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_pixel_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic [COL_W-1:0]  out_col_o,
  output logic              last_o
);

  logic              fwd_q;
  logic [HIST_W-1:0] fwd_data_q;
  logic [WIN_W-1:0]  all_q, all_d, any_q, any_d;
  logic [HIST_W-1:0] hist, vmask, new_hist;
  logic [WIN_W-1:0]  hmask, all_base, any_base;
  logic              vall, vany, ero, dil, res, emit, is_last;
  logic [ROW_W-1:0]  km1;
  logic              out_valid_q, out_pixel_q, last_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              fire;

  assign s1_adv_o = s1_i.valid && (!out_valid_q || !out_stall_i);
  assign fire     = s1_adv_o;

  assign hist     = fwd_q ? fwd_data_q : rd_data_i;
  assign vmask    = (HIST_W'(1) << (cfg_i.k - K_W'(1))) - HIST_W'(1);
  assign hmask    = (WIN_W'(1) << cfg_i.k) - WIN_W'(1);
  assign vall     = s1_i.px && ((hist & vmask) == vmask);
  assign vany     = s1_i.px || ((hist & vmask) != '0);
  assign new_hist = {hist[HIST_W-2:0], s1_i.px};

  assign all_base = (s1_i.col == '0) ? '0 : all_q;
  assign any_base = (s1_i.col == '0) ? '0 : any_q;
  assign all_d    = {all_base[WIN_W-2:0], vall};
  assign any_d    = {any_base[WIN_W-2:0], vany};
  assign ero      = (all_d & hmask) == hmask;
  assign dil      = (any_d & hmask) != '0;

  always_comb begin
    case (cfg_i.mode)
      MODE_ERODE:  res = ero;
      MODE_DILATE: res = dil;
      default:     res = dil && !ero;
    endcase
  end

  assign km1     = ROW_W'(cfg_i.k) - ROW_W'(1);
  assign emit    = (s1_i.row >= km1) && (s1_i.col >= COL_W'(km1));
  assign is_last = ({1'b0, s1_i.row} == cfg_i.height - DIM_W'(1))
                && ({1'b0, s1_i.col} == cfg_i.width - DIM_W'(1));

  assign wr_en_o   = fire;
  assign wr_addr_o = s1_i.col;
  assign wr_data_o = new_hist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= 1'b0;
      all_q       <= '0;
      any_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        fwd_q <= fire && (s1_i.col == rd_addr_i);
      end
      if (fire) begin
        all_q <= all_d;
        any_q <= any_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= new_hist;
    end
    if (fire && emit) begin
      out_pixel_q <= res;
      out_row_q   <= s1_i.row - km1;
      out_col_q   <= s1_i.col - COL_W'(km1);
      last_q      <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

  a_row_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (s1_i.col == '0) |=> (all_q[WIN_W-1:1] == '0) && (any_q[WIN_W-1:1] == '0))
    else $error("window flags not cleared at row start");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |->
      ({1'b0, out_row_q} + DIM_W'(cfg_i.k) - DIM_W'(1)) == cfg_i.height - DIM_W'(1))
    else $error("last item not anchored on final window row");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && emit))
    else $error("result item without a processed pixel");

endmodule

// File: hdl/binary_morphology_window_top.sv
// Binary erosion / dilation / gradient over a square all-ones window.
// Top level; depends on bmw_pkg, bmw_regs, bmw_scan, bmw_ram and bmw_window.
//
// Usage:
//   Pixel items enter on in_valid_i / in_stall_o with pixel_i and frame_start_i
//   (frame_start_i puts the pixel at row 0, column 0). Result items leave on
//   out_valid_o / out_stall_i with out_pixel_o, the window's top-left anchor in
//   out_row_o / out_col_o, and last_o on the final result of the frame. A result
//   is given once the window's bottom-right pixel has arrived; the last k-1 rows
//   and columns give none. A pixel is registered in the scan stage, its result
//   in the window stage's output register. Throughput: one pixel per cycle while
//   the receiver does not stall, set by the read-modify-write of one column history
//   entry per cycle in the line memory (one read and one write port). When the
//   receiver stalls, the output register holds, the window stage holds behind it
//   and in_stall_o rises; nothing is dropped. Reset clears position, window flags
//   and pipeline valids and loads the default registers (erosion, k = 3,
//   640 x 480). The line memory is not cleared; the first k-1 rows of a frame after
//   reset read entries not yet written. The user writes configuration via the
//   APB-style port while no item is in flight; the block does not check it.
module binary_morphology_window_top
  import bmw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              pixel_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_pixel_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic [COL_W-1:0]  out_col_o,
  output logic              last_o
);

  cfg_t              cfg;
  item_t             s1;
  logic              s1_adv;
  logic              rd_en, wr_en;
  logic [COL_W-1:0]  rd_addr, wr_addr;
  logic [HIST_W-1:0] rd_data, wr_data;

  bmw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bmw_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .s1_adv_i      (s1_adv),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .s1_o          (s1)
  );

  bmw_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (HIST_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bmw_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s1_i        (s1),
    .s1_adv_o    (s1_adv),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

endmodule
